@@ sv/rfctd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfctd_pkg
// Shared codes, types and constants of the receive FIFO with close-token
// detection.
// ----------------------------------------------------------------------------
package rfctd_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // configuration register indexes
  localparam logic REG_TOKEN_BYTES  = 1'b0;
  localparam logic REG_TOKEN_LENGTH = 1'b1;

  localparam int TOKEN_W     = 64;
  localparam int TOKEN_LEN_W = 4;
  localparam int MATCH_W     = 4;
  localparam int COUNT_OUT_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  // per-word status handed from the control unit to the result register
  typedef struct packed {
    logic                   accepted;
    logic                   read_hit;
    logic [COUNT_OUT_W-1:0] readable;
    logic                   closed;
  } status_t;

endpackage

@@ sv/rx_fifo_close_token_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_fifo_close_token_detector_core
// Receive FIFO that closes its stream once a configured close token is seen.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (op, in_byte) arrive on in_valid / in_stall; each produces
//   exactly one result word (accepted, read_valid, read_byte, readable_count,
//   stream_closed) on out_valid / out_stall. A word moves when valid is high
//   and stall is low.
//   Push, clear and no-op words: the result is registered at the accept edge
//   and shows on the next cycle. A read that pops a byte also goes through the
//   registered byte RAM read first, so throughput is one word per
//   cycle while out_stall is low; a popping read stalls input in ST_FETCH.
//   The output register frees in the same cycle it is taken, so a new word
//   is accepted while the previous result leaves.
//   While the receiver stalls a held result, in_stall stays high and the
//   result does not change. Reset (rst, synchronous) empties the FIFO, reopens
//   the stream and loads token_bytes = 0, token_length = 1; byte RAM contents
//   are not cleared. Configuration (cfg_write, cfg_index, cfg_data) is
//   written by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rx_fifo_close_token_detector_core #(
  parameter int FIFO_DEPTH      = 64,
  parameter int MAX_TOKEN_BYTES = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  cfg_write,
  input  logic                                  cfg_index,
  input  logic [rfctd_pkg::TOKEN_W-1:0]         cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            op,
  input  logic [7:0]                            in_byte,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  accepted,
  output logic                                  read_valid,
  output logic [7:0]                            read_byte,
  output logic [rfctd_pkg::COUNT_OUT_W-1:0]     readable_count,
  output logic                                  stream_closed
);

  localparam int PW = $clog2(FIFO_DEPTH);

  rfctd_pkg::state_t  state;
  rfctd_pkg::status_t status;

  logic [rfctd_pkg::TOKEN_W-1:0]     token_bytes;
  logic [rfctd_pkg::TOKEN_LEN_W-1:0] token_length;

  logic          step;
  logic          take_out;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // hold the input while a pop waits on the RAM or a result is stuck
  assign in_stall = (state != rfctd_pkg::ST_IDLE) || (out_valid && out_stall);
  assign step     = in_valid && !in_stall;
  assign take_out = out_valid && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      token_bytes  <= '0;
      token_length <= rfctd_pkg::TOKEN_LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        rfctd_pkg::REG_TOKEN_BYTES:  token_bytes  <= cfg_data;
        rfctd_pkg::REG_TOKEN_LENGTH: token_length <= cfg_data[rfctd_pkg::TOKEN_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfctd_ctrl #(
    .FIFO_DEPTH      (FIFO_DEPTH),
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .op           (op),
    .in_byte      (in_byte),
    .token_bytes  (token_bytes),
    .token_length (token_length),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .status       (status)
  );

  // Byte store. A push and a read never share a word, and a pushed entry
  // is written at its accept edge, before any later read can address it,
  // so no forwarding path is needed.
  rfctd_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control: sequencer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfctd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        rfctd_pkg::ST_IDLE: begin
          if (step) begin
            if (status.read_hit) begin
              // move to ST_FETCH and wait there for the popped byte
              state     <= rfctd_pkg::ST_FETCH;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (take_out) begin
            out_valid <= 1'b0;
          end
        end
        rfctd_pkg::ST_FETCH: begin
          state     <= rfctd_pkg::ST_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state     <= rfctd_pkg::ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // result payload: load status at accept, fill in the byte after the fetch
  always_ff @(posedge clk) begin
    if (step) begin
      accepted       <= status.accepted;
      read_valid     <= status.read_hit;
      read_byte      <= '0;
      readable_count <= status.readable;
      stream_closed  <= status.closed;
    end else if (state == rfctd_pkg::ST_FETCH) begin
      read_byte <= ram_rdata;
    end
  end

`ifndef SYNTHESIS
  // a popping read always leads to a fetch cycle and then a valid result
  a_fetch_seq: assert property (@(posedge clk) disable iff (rst)
    (step && status.read_hit) |=> (state == rfctd_pkg::ST_FETCH) ##1 out_valid)
    else $error("popping read did not deliver a result after the fetch");

  // no word is taken while the byte fetch is outstanding
  a_fetch_stall: assert property (@(posedge clk) disable iff (rst)
    (state == rfctd_pkg::ST_FETCH) |-> (in_stall && !out_valid))
    else $error("input taken or result shown during fetch");

  // a result never both stores and pops a byte
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && read_valid))
    else $error("result reports both push and pop");

  // a closed stream has nothing left to read
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_closed) |-> (readable_count == '0))
    else $error("stream closed with readable bytes");
`endif

endmodule

@@ sv/rfctd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfctd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rfctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rfctd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfctd_ctrl
// Pointer, fill and token-match state; issues RAM accesses and computes the
// status of each word after its step.
// ----------------------------------------------------------------------------
module rfctd_ctrl #(
  parameter int FIFO_DEPTH      = 64,
  parameter int MAX_TOKEN_BYTES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic [1:0]                           op,
  input  logic [7:0]                           in_byte,
  input  logic [rfctd_pkg::TOKEN_W-1:0]        token_bytes,
  input  logic [rfctd_pkg::TOKEN_LEN_W-1:0]    token_length,
  output logic                                 ram_we,
  output logic [$clog2(FIFO_DEPTH)-1:0]        ram_waddr,
  output logic [7:0]                           ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(FIFO_DEPTH)-1:0]        ram_raddr,
  output rfctd_pkg::status_t                   status
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int MW = rfctd_pkg::MATCH_W;
  localparam int CW = (PW > MW) ? PW : MW;
  localparam logic [PW-1:0] LAST_IDX = PW'(FIFO_DEPTH - 1);

  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] fill, fill_next;
  logic [MW-1:0] match_cnt, match_cnt_next;
  logic          closed, closed_next;

  logic [MW-1:0] len;
  logic [7:0]    tok_cur;
  logic [MW-1:0] hit_cnt;
  logic          push_ok;
  logic          read_ok;
  logic [CW-1:0] readable_now;
  logic [CW-1:0] readable_after;

  function automatic logic [CW-1:0] readable_of(input logic [PW-1:0] f,
                                                input logic [MW-1:0] m);
    logic [CW-1:0] fw;
    logic [CW-1:0] mw;
    begin
      fw = CW'(f);
      mw = CW'(m);
      return (fw > mw) ? (fw - mw) : '0;
    end
  endfunction

  // clamp token length into 1..MAX_TOKEN_BYTES
  always_comb begin
    if (token_length == '0) begin
      len = MW'(1);
    end else if (token_length > MW'(MAX_TOKEN_BYTES)) begin
      len = MW'(MAX_TOKEN_BYTES);
    end else begin
      len = token_length;
    end
  end

  assign tok_cur      = token_bytes[{match_cnt[2:0], 3'b000} +: 8];
  assign push_ok      = !closed && (fill != LAST_IDX);
  assign readable_now = readable_of(fill, match_cnt);
  assign read_ok      = (readable_now != '0);

  // advance on a token hit, restart at one on the first byte, else drop
  always_comb begin
    if ((match_cnt < len) && (in_byte == tok_cur)) begin
      hit_cnt = match_cnt + MW'(1);
    end else if (in_byte == token_bytes[7:0]) begin
      hit_cnt = MW'(1);
    end else begin
      hit_cnt = '0;
    end
  end

  always_comb begin
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    fill_next      = fill;
    match_cnt_next = match_cnt;
    closed_next    = closed;
    case (op)
      rfctd_pkg::OP_PUSH: begin
        if (push_ok) begin
          wr_ptr_next    = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PW'(1);
          fill_next      = fill + PW'(1);
          match_cnt_next = hit_cnt;
          closed_next    = (hit_cnt >= len);
        end
      end
      rfctd_pkg::OP_READ: begin
        if (read_ok) begin
          rd_ptr_next = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PW'(1);
          fill_next   = fill - PW'(1);
        end
      end
      rfctd_pkg::OP_CLEAR: begin
        wr_ptr_next    = '0;
        rd_ptr_next    = '0;
        fill_next      = '0;
        match_cnt_next = '0;
        closed_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign readable_after = readable_of(fill_next, match_cnt_next);

  always_comb begin
    status.accepted = (op == rfctd_pkg::OP_PUSH) && push_ok;
    status.read_hit = (op == rfctd_pkg::OP_READ) && read_ok;
    status.readable = rfctd_pkg::COUNT_OUT_W'(readable_after);
    status.closed   = closed_next && (readable_after == '0);
  end

  assign ram_we    = step && status.accepted;
  assign ram_waddr = wr_ptr;
  assign ram_wdata = in_byte;
  assign ram_re    = step && status.read_hit;
  assign ram_raddr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fill      <= '0;
      match_cnt <= '0;
      closed    <= 1'b0;
    end else if (step) begin
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      fill      <= fill_next;
      match_cnt <= match_cnt_next;
      closed    <= closed_next;
    end
  end

endmodule

@@ test/tb_rx_fifo_close_token_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rx_fifo_close_token_detector_core
// Self-checking bench for the receive FIFO with close-token detection. A
// shadow FIFO, updated at every accepted input word, predicts each status
// word; a checker compares every result word field by field, in order.
// Directed words cover reset state, closing, restart of a partial match and
// token length changes; then a full ring, a long receiver hold-off and
// random traffic over several token settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_rx_fifo_close_token_detector_core;

  localparam int DEPTH     = 64;
  localparam int MAX_TOKEN = 8;

  // one predicted status word, laid out like the result channel
  typedef struct packed {
    logic                              accepted;
    logic                              read_valid;
    logic [7:0]                        read_byte;
    logic [rfctd_pkg::COUNT_OUT_W-1:0] readable_count;
    logic                              stream_closed;
  } fifo_status_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic                              cfg_index = rfctd_pkg::REG_TOKEN_BYTES;
  logic [rfctd_pkg::TOKEN_W-1:0]     cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [1:0]                        op = rfctd_pkg::OP_NOP;
  logic [7:0]                        in_byte = 8'h00;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              accepted;
  logic                              read_valid;
  logic [7:0]                        read_byte;
  logic [rfctd_pkg::COUNT_OUT_W-1:0] readable_count;
  logic                              stream_closed;

  rx_fifo_close_token_detector_core #(
    .FIFO_DEPTH(DEPTH),
    .MAX_TOKEN_BYTES(MAX_TOKEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .accepted(accepted),
    .read_valid(read_valid),
    .read_byte(read_byte),
    .readable_count(readable_count),
    .stream_closed(stream_closed)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow FIFO: its own copy of the ring, pointers, match count and token
  // registers, all at reset values until the first accepted word.
  // --------------------------------------------------------------------------
  logic [7:0]                        shadow_store [DEPTH];
  logic [5:0]                        wr_ptr_q = '0;
  logic [5:0]                        rd_ptr_q = '0;
  logic [rfctd_pkg::MATCH_W-1:0]     match_q = '0;
  logic                              closed_q = 1'b0;
  logic [rfctd_pkg::TOKEN_W-1:0]     token_q = '0;
  logic [rfctd_pkg::TOKEN_LEN_W-1:0] token_len_q = 4'd1;

  fifo_status_t expected_status_q [$];
  fifo_status_t oldest_status;

  int mismatches     = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int pushes_refused = 0;
  int closes_seen    = 0;
  int reads_popped   = 0;

  // stimulus knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  // Clamp the length register: zero acts as one, above the maximum as the maximum.
  function automatic logic [3:0] eff_token_len();
    if (token_len_q == 0) return 4'd1;
    if (token_len_q > MAX_TOKEN) return 4'(MAX_TOKEN);
    return token_len_q;
  endfunction

  function automatic logic [7:0] token_byte(input logic [3:0] idx);
    return token_q[idx[2:0]*8 +: 8];
  endfunction

  function automatic logic [5:0] fill_level();
    return wr_ptr_q - rd_ptr_q;
  endfunction

  // Stored bytes minus the ones held back by a partial or full match.
  function automatic logic [5:0] readable_now();
    logic [5:0] fill;
    fill = fill_level();
    return (fill > match_q) ? fill - 6'(match_q) : 6'd0;
  endfunction

  // Advance the shadow FIFO by one word and return the status it reports.
  function automatic fifo_status_t model_fifo_word(input logic [1:0] w_op,
                                                   input logic [7:0] w_byte);
    fifo_status_t res;
    logic [3:0]   len;
    res = '0;
    len = eff_token_len();
    case (w_op)
      rfctd_pkg::OP_PUSH: begin
        if (!closed_q && fill_level() < DEPTH - 1) begin
          // a count left at or above a shortened length counts as a mismatch
          if (match_q < len && w_byte == token_byte(match_q))
            match_q = match_q + 1'b1;
          else if (w_byte == token_byte(4'd0))
            match_q = 4'd1;
          else
            match_q = 4'd0;
          if (match_q >= len) begin
            closed_q = 1'b1;
            closes_seen++;
          end
          shadow_store[wr_ptr_q] = w_byte;
          wr_ptr_q = wr_ptr_q + 1'b1;
          res.accepted = 1'b1;
        end else begin
          pushes_refused++;
        end
      end
      rfctd_pkg::OP_READ: begin
        if (readable_now() != 0) begin
          res.read_valid = 1'b1;
          res.read_byte  = shadow_store[rd_ptr_q];
          rd_ptr_q = rd_ptr_q + 1'b1;
          reads_popped++;
        end
      end
      rfctd_pkg::OP_CLEAR: begin
        wr_ptr_q = '0;
        rd_ptr_q = '0;
        match_q  = '0;
        closed_q = 1'b0;
      end
      default: ;
    endcase
    res.readable_count = readable_now();
    res.stream_closed  = closed_q && (res.readable_count == 0);
    return res;
  endfunction

  // Track register writes and predict every accepted input word.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          rfctd_pkg::REG_TOKEN_BYTES:  token_q = cfg_data;
          rfctd_pkg::REG_TOKEN_LENGTH: token_len_q = cfg_data[rfctd_pkg::TOKEN_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_status_q.push_back(model_fifo_word(op, in_byte));
        words_sent++;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_status_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word arrived with nothing predicted", $time);
      end else begin
        oldest_status = expected_status_q.pop_front();
        check_field("accepted", 8'(oldest_status.accepted), 8'(accepted));
        check_field("read_valid", 8'(oldest_status.read_valid), 8'(read_valid));
        check_field("read_byte", oldest_status.read_byte, read_byte);
        check_field("readable_count", 8'(oldest_status.readable_count),
                    8'(readable_count));
        check_field("stream_closed", 8'(oldest_status.stream_closed),
                    8'(stream_closed));
        results_seen++;
      end
    end
  end

  // Receiver: stall at random, or hold off for a counted stretch on request.
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    if (hold_left != 0) hold_left = hold_left - 1;
  end

  // --------------------------------------------------------------------------
  // Sender side. Every task starts and ends in the time step of a rising
  // edge, so each drive below is the only one to its signal in that step.
  // --------------------------------------------------------------------------

  // Offer one word after a random gap; hold it until the block takes it.
  task automatic send_word(input logic [1:0] w_op, input logic [7:0] w_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= w_op;
    in_byte  <= w_byte;
    do @(posedge clk); while (in_stall);
  endtask

  // Non-push words carry a random byte so the unused field still toggles.
  task automatic send_op(input logic [1:0] w_op);
    send_word(w_op, 8'($urandom_range(255)));
  endtask

  // Drop valid and wait until every predicted word has come back; the
  // first edge lets the prediction of the last accepted word land.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; call only once the block is idle.
  task automatic write_reg(input logic idx, input logic [rfctd_pkg::TOKEN_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Length write with random upper bits, which the block must ignore.
  task automatic write_len(input logic [3:0] len);
    logic [rfctd_pkg::TOKEN_W-1:0] data;
    data = {$urandom(), $urandom()};
    data[rfctd_pkg::TOKEN_LEN_W-1:0] = len;
    write_reg(rfctd_pkg::REG_TOKEN_LENGTH, data);
  endtask

  // Half the data bytes come from the token, so matches start often.
  function automatic logic [7:0] pick_data_byte();
    if ($urandom_range(1) == 1) return token_byte(4'($urandom_range(7)));
    return 8'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset state: token 0x00 of length 1, empty ring.
  task automatic test_reset_state();
    send_op(rfctd_pkg::OP_NOP);
    send_op(rfctd_pkg::OP_READ);            // nothing readable yet
    send_word(rfctd_pkg::OP_PUSH, 8'hFF);
    send_word(rfctd_pkg::OP_PUSH, 8'h01);
    send_op(rfctd_pkg::OP_READ);
    send_op(rfctd_pkg::OP_READ);
    send_op(rfctd_pkg::OP_READ);            // empty again
  endtask

  // A one-byte token closes at once; pushes are refused until a clear.
  task automatic test_close_and_clear();
    send_word(rfctd_pkg::OP_PUSH, 8'h00);
    send_word(rfctd_pkg::OP_PUSH, 8'h5A);
    send_op(rfctd_pkg::OP_READ);
    send_op(rfctd_pkg::OP_CLEAR);
    send_op(rfctd_pkg::OP_NOP);
  endtask

  // Partial match restarts at one on a first-byte repeat; held bytes stay back.
  task automatic test_partial_match();
    wait_idle();
    write_reg(rfctd_pkg::REG_TOKEN_BYTES, 64'h0000_0000_0043_4241);
    write_len(4'd3);
    send_word(rfctd_pkg::OP_PUSH, 8'h41);
    send_word(rfctd_pkg::OP_PUSH, 8'h42);
    send_word(rfctd_pkg::OP_PUSH, 8'h41);
    send_word(rfctd_pkg::OP_PUSH, 8'h42);
    send_op(rfctd_pkg::OP_READ);
    send_word(rfctd_pkg::OP_PUSH, 8'h43);   // closes with one byte still readable
    send_op(rfctd_pkg::OP_CLEAR);
  endtask

  // Shrink the length below a running count, then try a length of zero.
  task automatic test_length_change();
    wait_idle();
    write_reg(rfctd_pkg::REG_TOKEN_BYTES, 64'h8877_6655_4433_2211);
    write_len(4'd8);
    send_word(rfctd_pkg::OP_PUSH, 8'h11);
    send_word(rfctd_pkg::OP_PUSH, 8'h22);
    send_word(rfctd_pkg::OP_PUSH, 8'h33);
    send_word(rfctd_pkg::OP_PUSH, 8'h44);
    wait_idle();
    write_len(4'd2);
    send_word(rfctd_pkg::OP_PUSH, 8'h11);   // count past the length: restart at one
    send_word(rfctd_pkg::OP_PUSH, 8'h22);
    send_op(rfctd_pkg::OP_CLEAR);
    wait_idle();
    write_len(4'd0);
    send_word(rfctd_pkg::OP_PUSH, 8'h11);
    send_op(rfctd_pkg::OP_CLEAR);
  endtask

  // Fill the ring to its last free slot, refuse one more, then drain it.
  task automatic test_ring_full();
    wait_idle();
    write_reg(rfctd_pkg::REG_TOKEN_BYTES, 64'h0);
    write_len(4'd8);
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    repeat (DEPTH) send_word(rfctd_pkg::OP_PUSH, 8'($urandom_range(255, 1)));
    repeat (DEPTH) send_op(rfctd_pkg::OP_READ);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off while pushes keep coming, so the block backs up.
  task automatic test_backpressure();
    wait_idle();
    write_reg(rfctd_pkg::REG_TOKEN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_len(4'd8);
    send_op(rfctd_pkg::OP_CLEAR);
    in_valid <= 1'b0;
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    repeat (24) send_word(rfctd_pkg::OP_PUSH, 8'($urandom_range(255)));
    wait_idle();                 // pause until every result is back
    repeat (24) send_op(rfctd_pkg::OP_READ);
  endtask

  // One random phase: mostly token runs, pushes and reads, with some
  // broken token runs, clears and no-ops thrown in.
  task automatic run_random_phase(input int n, input logic [rfctd_pkg::TOKEN_W-1:0] tok,
                                  input logic [3:0] len, input int idle_pct,
                                  input int stall_pct);
    int         sent;
    int         pick;
    int         bad_at;
    logic [3:0] run_len;
    logic [7:0] b;
    wait_idle();
    write_reg(rfctd_pkg::REG_TOKEN_BYTES, tok);
    write_len(len);
    send_op(rfctd_pkg::OP_CLEAR);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // whole token, sometimes with one byte spoiled
        run_len = eff_token_len();
        bad_at  = ($urandom_range(2) == 0) ? $urandom_range(run_len - 1) : -1;
        for (int i = 0; i < run_len; i++) begin
          b = token_byte(4'(i));
          if (i == bad_at) b = 8'($urandom_range(255));
          send_word(rfctd_pkg::OP_PUSH, b);
        end
        sent += run_len;
      end else begin
        if (pick < 55)      send_word(rfctd_pkg::OP_PUSH, pick_data_byte());
        else if (pick < 88) send_op(rfctd_pkg::OP_READ);
        else if (pick < 92) send_op(rfctd_pkg::OP_CLEAR);
        else if (pick < 96) send_op(rfctd_pkg::OP_NOP);
        else                send_word(rfctd_pkg::OP_PUSH, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(155, {$urandom(), $urandom()}, 4'd1, 0, 0);
    run_random_phase(155, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 74, 0);
    run_random_phase(155, {$urandom(), $urandom()}, 4'd3, 0, 74);
    run_random_phase(155, 64'h0, 4'd15, 18, 18);   // above the max acts as eight
    run_random_phase(155, {$urandom(), $urandom()}, 4'd5, 18, 18);
    run_random_phase(155, {$urandom(), $urandom()}, 4'd2, 0, 0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, report.
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_close_and_clear();
    test_partial_match();
    test_length_change();
    test_ring_full();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d words and %0d results: %0d bytes popped, %0d pushes refused,",
             words_sent, results_seen, reads_popped, pushes_refused);
    $display("%0d stream closes, over token lengths 0..15 and idle/stall mixes",
             closes_seen);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("tb_rx_fifo_close_token_detector_core: PASS");
    end else begin
      $display("tb_rx_fifo_close_token_detector_core: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("%0t ns: timeout, %0d results still outstanding", $time,
             expected_status_q.size());
    $display("tb_rx_fifo_close_token_detector_core: FAIL");
    $finish;
  end

endmodule
